>>> sv/bdrm_pkg.sv
// Shared types, constants and the popcount function of the descriptor ratio matcher.
`timescale 1ns / 1ps

package bdrm_pkg;

  localparam int DESC_WORDS    = 4;
  localparam int WORD_BITS     = 64;
  localparam int MAX_KEYPOINTS = 1024;
  localparam int IDX_BITS      = 10;
  localparam int DIST_BITS     = 9;
  localparam int LVL_BITS      = 4;
  localparam int OCT_BITS      = 3;
  localparam int POP_BITS      = 7;

  localparam logic [DIST_BITS-1:0] DIST_NONE = 9'd256;
  localparam logic [LVL_BITS-1:0]  NO_LEVEL  = 4'd15;

  localparam logic [WORD_BITS-1:0] POP_M1 = 64'h5555_5555_5555_5555;
  localparam logic [WORD_BITS-1:0] POP_M2 = 64'h3333_3333_3333_3333;
  localparam logic [WORD_BITS-1:0] POP_M4 = 64'h0F0F_0F0F_0F0F_0F0F;

  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_CAND   = 2'd1;
  localparam logic [1:0] KIND_FINISH = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_COUNT,
    ST_UPDATE
  } state_t;

  typedef struct packed {
    logic       load_query;
    logic       capture;
    logic       count;
    logic [1:0] word_sel;
    logic       update;
    logic       emit;
  } cmd_t;

  typedef struct packed {
    logic cand_skip;
  } status_t;

  function automatic logic [POP_BITS-1:0] popcount64(input logic [WORD_BITS-1:0] v);
    logic [WORD_BITS-1:0] s1;
    logic [WORD_BITS-1:0] s2;
    logic [WORD_BITS-1:0] s3;
    logic [POP_BITS-1:0]  sum;
    s1  = v - ((v >> 1) & POP_M1);
    s2  = (s1 & POP_M2) + ((s1 >> 2) & POP_M2);
    s3  = (s2 + (s2 >> 4)) & POP_M4;
    sum = '0;
    for (int i = 0; i < 8; i++) begin
      sum = sum + {3'b000, s3[8*i +: 4]};
    end
    return sum;
  endfunction

endpackage

>>> sv/bdrm_ctrl.sv
// Controller state machine of the descriptor ratio matcher.
`timescale 1ns / 1ps

module bdrm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [1:0]         in_kind,
  input  bdrm_pkg::status_t  status,
  output logic               busy,
  output bdrm_pkg::cmd_t     cmd
);

  bdrm_pkg::state_t state_r, state_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bdrm_pkg::ST_IDLE;
      cnt_r   <= 2'd0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    busy      = 1'b1;
    unique case (state_r)
      bdrm_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          unique case (in_kind)
            bdrm_pkg::KIND_QUERY: begin
              cmd.load_query = 1'b1;
            end
            bdrm_pkg::KIND_CAND: begin
              if (!status.cand_skip) begin
                cmd.capture = 1'b1;
                cnt_nxt     = 2'd0;
                state_nxt   = bdrm_pkg::ST_COUNT;
              end
            end
            bdrm_pkg::KIND_FINISH: begin
              cmd.emit = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      bdrm_pkg::ST_COUNT: begin
        cmd.count    = 1'b1;
        cmd.word_sel = cnt_r;
        cnt_nxt      = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = bdrm_pkg::ST_UPDATE;
        end
      end
      bdrm_pkg::ST_UPDATE: begin
        cmd.update = 1'b1;
        state_nxt  = bdrm_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = bdrm_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

>>> sv/bdrm_datapath.sv
// Datapath of the descriptor ratio matcher: descriptor storage, popcount, best tracking.
`timescale 1ns / 1ps

module bdrm_datapath (
  input  logic                           clk,
  input  logic                           rst_n,
  input  bdrm_pkg::cmd_t                 cmd,
  output bdrm_pkg::status_t              status,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_0,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_1,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_2,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_3,
  input  logic [bdrm_pkg::OCT_BITS-1:0]  in_octave,
  input  logic [bdrm_pkg::IDX_BITS-1:0]  in_cand_index,
  input  logic                           in_taken,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic [bdrm_pkg::IDX_BITS-1:0]  out_best_index,
  output logic [bdrm_pkg::DIST_BITS-1:0] out_best_distance,
  output logic [bdrm_pkg::DIST_BITS-1:0] out_second_distance
);

  logic [bdrm_pkg::WORD_BITS-1:0] query_r [bdrm_pkg::DESC_WORDS];
  logic [bdrm_pkg::WORD_BITS-1:0] cand_r  [bdrm_pkg::DESC_WORDS];
  logic [bdrm_pkg::LVL_BITS-1:0]  cand_lvl_r;
  logic [bdrm_pkg::IDX_BITS-1:0]  cand_idx_r;
  logic [bdrm_pkg::DIST_BITS-1:0] acc_r;
  logic [bdrm_pkg::DIST_BITS-1:0] best_dist_r;
  logic [bdrm_pkg::DIST_BITS-1:0] second_dist_r;
  logic [bdrm_pkg::LVL_BITS-1:0]  best_lvl_r;
  logic [bdrm_pkg::LVL_BITS-1:0]  second_lvl_r;
  logic [bdrm_pkg::IDX_BITS-1:0]  best_idx_r;
  logic                           have_best_r;
  logic                           out_valid_r;
  logic                           out_accepted_r;
  logic [bdrm_pkg::IDX_BITS-1:0]  out_best_index_r;
  logic [bdrm_pkg::DIST_BITS-1:0] out_best_distance_r;
  logic [bdrm_pkg::DIST_BITS-1:0] out_second_distance_r;

  logic [bdrm_pkg::POP_BITS-1:0]  word_pop;
  logic [11:0]                    best_x5;
  logic [11:0]                    second_x4;
  logic                           reject;

  assign status.cand_skip = in_taken ||
      ({1'b0, in_cand_index} >= 11'(bdrm_pkg::MAX_KEYPOINTS));

  assign word_pop  = bdrm_pkg::popcount64(query_r[cmd.word_sel] ^ cand_r[cmd.word_sel]);
  assign best_x5   = {1'b0, best_dist_r, 2'b00} + {3'b000, best_dist_r};
  assign second_x4 = {1'b0, second_dist_r, 2'b00};
  assign reject    = (best_lvl_r == second_lvl_r) && (best_x5 > second_x4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < bdrm_pkg::DESC_WORDS; i++) begin
        query_r[i] <= '0;
      end
      best_dist_r   <= bdrm_pkg::DIST_NONE;
      second_dist_r <= bdrm_pkg::DIST_NONE;
      best_lvl_r    <= bdrm_pkg::NO_LEVEL;
      second_lvl_r  <= bdrm_pkg::NO_LEVEL;
      best_idx_r    <= '0;
      have_best_r   <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.load_query) begin
        query_r[0]    <= in_desc_word_0;
        query_r[1]    <= in_desc_word_1;
        query_r[2]    <= in_desc_word_2;
        query_r[3]    <= in_desc_word_3;
        best_dist_r   <= bdrm_pkg::DIST_NONE;
        second_dist_r <= bdrm_pkg::DIST_NONE;
        best_lvl_r    <= bdrm_pkg::NO_LEVEL;
        second_lvl_r  <= bdrm_pkg::NO_LEVEL;
        best_idx_r    <= '0;
        have_best_r   <= 1'b0;
      end else if (cmd.update) begin
        if (acc_r < best_dist_r) begin
          second_dist_r <= best_dist_r;
          second_lvl_r  <= best_lvl_r;
          best_dist_r   <= acc_r;
          best_lvl_r    <= cand_lvl_r;
          best_idx_r    <= cand_idx_r;
          have_best_r   <= 1'b1;
        end else if (acc_r < second_dist_r) begin
          second_dist_r <= acc_r;
          second_lvl_r  <= cand_lvl_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cand_r[0]  <= in_desc_word_0;
      cand_r[1]  <= in_desc_word_1;
      cand_r[2]  <= in_desc_word_2;
      cand_r[3]  <= in_desc_word_3;
      cand_lvl_r <= {1'b0, in_octave};
      cand_idx_r <= in_cand_index;
      acc_r      <= '0;
    end else if (cmd.count) begin
      acc_r <= acc_r + {2'b00, word_pop};
    end
    if (cmd.emit) begin
      out_accepted_r        <= !reject;
      out_best_index_r      <= have_best_r ? best_idx_r : '0;
      out_best_distance_r   <= best_dist_r;
      out_second_distance_r <= second_dist_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_accepted        = out_accepted_r;
  assign out_best_index      = out_best_index_r;
  assign out_best_distance   = out_best_distance_r;
  assign out_second_distance = out_second_distance_r;

endmodule

>>> sv/binary_descriptor_ratio_matcher_core.sv
// Top level of the binary descriptor ratio matcher.
`timescale 1ns / 1ps

// Items are taken when start is high and busy is low. A query item, a finish item and a
// skipped candidate (taken, or index out of range) leave busy low. A scored candidate
// holds busy until it is scored, so no new item is taken before then: a shared 64-bit
// popcount unit scores one descriptor word per cycle, then an update step compares the
// distance against the best and second-best. The result of a finish item appears on the
// out_ ports, flagged by out_valid, for exactly one cycle, the cycle after the item is
// taken; the receiver cannot hold it off, so it must capture it then.
module binary_descriptor_ratio_matcher_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     in_kind,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_0,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_1,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_2,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_3,
  input  logic [bdrm_pkg::OCT_BITS-1:0]  in_octave,
  input  logic [bdrm_pkg::IDX_BITS-1:0]  in_cand_index,
  input  logic                           in_taken,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic [bdrm_pkg::IDX_BITS-1:0]  out_best_index,
  output logic [bdrm_pkg::DIST_BITS-1:0] out_best_distance,
  output logic [bdrm_pkg::DIST_BITS-1:0] out_second_distance
);

  bdrm_pkg::cmd_t    cmd;
  bdrm_pkg::status_t status;

  bdrm_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .in_kind (in_kind),
    .status  (status),
    .busy    (busy),
    .cmd     (cmd)
  );

  bdrm_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .status              (status),
    .in_desc_word_0      (in_desc_word_0),
    .in_desc_word_1      (in_desc_word_1),
    .in_desc_word_2      (in_desc_word_2),
    .in_desc_word_3      (in_desc_word_3),
    .in_octave           (in_octave),
    .in_cand_index       (in_cand_index),
    .in_taken            (in_taken),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_best_index      (out_best_index),
    .out_best_distance   (out_best_distance),
    .out_second_distance (out_second_distance)
  );

`ifndef NO_ASSERTIONS
  a_result_follows_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_kind == bdrm_pkg::KIND_FINISH))
    else $error("result without a finish item");

  a_scored_cand_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_kind == bdrm_pkg::KIND_CAND && !status.cand_skip) |=> busy)
    else $error("scored candidate did not hold busy");

  a_best_not_above_second: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_best_distance <= out_second_distance))
    else $error("best distance above second distance");
`endif

endmodule

>>> tb/bdrm_match_checker.sv
// Checker that predicts the matcher's results and compares them with the result port.
`timescale 1ns / 1ps

module bdrm_match_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic                           busy,
  input  logic [1:0]                     in_kind,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_0,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_1,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_2,
  input  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_3,
  input  logic [bdrm_pkg::OCT_BITS-1:0]  in_octave,
  input  logic [bdrm_pkg::IDX_BITS-1:0]  in_cand_index,
  input  logic                           in_taken,
  input  logic                           out_valid,
  input  logic                           out_accepted,
  input  logic [bdrm_pkg::IDX_BITS-1:0]  out_best_index,
  input  logic [bdrm_pkg::DIST_BITS-1:0] out_best_distance,
  input  logic [bdrm_pkg::DIST_BITS-1:0] out_second_distance,
  output int                             mismatch_count,
  output int                             pending_results
);

  localparam int DESC_W    = bdrm_pkg::DESC_WORDS * bdrm_pkg::WORD_BITS;
  localparam int DUE_DEPTH = 8;

  typedef struct {
    logic                           accepted;
    logic [bdrm_pkg::IDX_BITS-1:0]  best_index;
    logic [bdrm_pkg::DIST_BITS-1:0] best_distance;
    logic [bdrm_pkg::DIST_BITS-1:0] second_distance;
  } match_result_t;

  match_result_t due_matches [DUE_DEPTH];
  int            due_head;
  int            due_tail;
  int            due_fill;

  logic [DESC_W-1:0]              query_bits;
  logic [bdrm_pkg::DIST_BITS-1:0] lead_dist;
  logic [bdrm_pkg::DIST_BITS-1:0] runner_dist;
  logic [bdrm_pkg::LVL_BITS-1:0]  lead_level;
  logic [bdrm_pkg::LVL_BITS-1:0]  runner_level;
  logic [bdrm_pkg::IDX_BITS-1:0]  lead_index;
  logic                           lead_seen;

  task automatic clear_search();
    lead_dist    = bdrm_pkg::DIST_NONE;
    runner_dist  = bdrm_pkg::DIST_NONE;
    lead_level   = bdrm_pkg::NO_LEVEL;
    runner_level = bdrm_pkg::NO_LEVEL;
    lead_index   = '0;
    lead_seen    = 1'b0;
  endtask

  task automatic store_result(input match_result_t want);
    if (due_fill == DUE_DEPTH) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t expected results overflow", $realtime);
    end else begin
      due_matches[due_tail] = want;
      due_tail = (due_tail + 1) % DUE_DEPTH;
      due_fill++;
    end
  endtask

  task automatic take_result(output match_result_t want);
    want     = due_matches[due_head];
    due_head = (due_head + 1) % DUE_DEPTH;
    due_fill--;
  endtask

  task automatic score_item();
    logic [DESC_W-1:0] cand_bits;
    int unsigned       ham_d;
    match_result_t     want;
    cand_bits = {in_desc_word_3, in_desc_word_2, in_desc_word_1, in_desc_word_0};
    case (in_kind)
      bdrm_pkg::KIND_QUERY: begin
        query_bits = cand_bits;
        clear_search();
      end
      bdrm_pkg::KIND_CAND: begin
        if (!in_taken && in_cand_index < bdrm_pkg::MAX_KEYPOINTS) begin
          ham_d = $countones(query_bits ^ cand_bits);
          if (ham_d < lead_dist) begin
            runner_dist  = lead_dist;
            runner_level = lead_level;
            lead_dist    = ham_d[bdrm_pkg::DIST_BITS-1:0];
            lead_level   = {1'b0, in_octave};
            lead_index   = in_cand_index;
            lead_seen    = 1'b1;
          end else if (ham_d < runner_dist) begin
            runner_dist  = ham_d[bdrm_pkg::DIST_BITS-1:0];
            runner_level = {1'b0, in_octave};
          end
        end
      end
      bdrm_pkg::KIND_FINISH: begin
        want.accepted = !((lead_level == runner_level) &&
                          (5 * int'(lead_dist) > 4 * int'(runner_dist)));
        want.best_index      = lead_seen ? lead_index : '0;
        want.best_distance   = lead_dist;
        want.second_distance = runner_dist;
        store_result(want);
      end
      default: begin
      end
    endcase
  endtask

  always @(posedge clk) begin
    match_result_t want;
    if (!rst_n) begin
      query_bits = '0;
      clear_search();
      due_head       = 0;
      due_tail       = 0;
      due_fill       = 0;
      mismatch_count = 0;
    end else begin
      if (out_valid) begin
        if (due_fill == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("%0t unexpected result: accepted=%0d index=%0d best=%0d second=%0d",
                     $realtime, out_accepted, out_best_index, out_best_distance,
                     out_second_distance);
        end else begin
          take_result(want);
          if (out_accepted !== want.accepted || out_best_index !== want.best_index ||
              out_best_distance !== want.best_distance ||
              out_second_distance !== want.second_distance) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("%0t mismatch exp/act: acc %0d/%0d idx %0d/%0d best %0d/%0d 2nd %0d/%0d",
                       $realtime, want.accepted, out_accepted, want.best_index,
                       out_best_index, want.best_distance, out_best_distance,
                       want.second_distance, out_second_distance);
          end
        end
      end
      if (start && !busy)
        score_item();
    end
    pending_results <= due_fill;
  end

endmodule

>>> tb/binary_descriptor_ratio_matcher_core_tb.sv
// Testbench top: drives query, candidate and finish items into the matcher and gives the verdict.
`timescale 1ns / 1ps

module binary_descriptor_ratio_matcher_core_tb;

  localparam int         DESC_W      = bdrm_pkg::DESC_WORDS * bdrm_pkg::WORD_BITS;
  localparam int         ITEM_TOTAL  = 1350;
  localparam int         QUIET_AFTER = 1150;
  localparam int         CYCLE_LIMIT = 400000;
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                           clk;
  logic                           rst_n;
  logic                           start;
  logic                           busy;
  logic [1:0]                     in_kind;
  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_0;
  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_1;
  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_2;
  logic [bdrm_pkg::WORD_BITS-1:0] in_desc_word_3;
  logic [bdrm_pkg::OCT_BITS-1:0]  in_octave;
  logic [bdrm_pkg::IDX_BITS-1:0]  in_cand_index;
  logic                           in_taken;
  logic                           out_valid;
  logic                           out_accepted;
  logic [bdrm_pkg::IDX_BITS-1:0]  out_best_index;
  logic [bdrm_pkg::DIST_BITS-1:0] out_best_distance;
  logic [bdrm_pkg::DIST_BITS-1:0] out_second_distance;
  int                             mismatch_count;
  int                             pending_results;
  int                             cycle_count = 0;
  int                             items_sent;
  logic                           gaps_on;
  logic                           paused_once;

  binary_descriptor_ratio_matcher_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_desc_word_0      (in_desc_word_0),
    .in_desc_word_1      (in_desc_word_1),
    .in_desc_word_2      (in_desc_word_2),
    .in_desc_word_3      (in_desc_word_3),
    .in_octave           (in_octave),
    .in_cand_index       (in_cand_index),
    .in_taken            (in_taken),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_best_index      (out_best_index),
    .out_best_distance   (out_best_distance),
    .out_second_distance (out_second_distance)
  );

  bdrm_match_checker u_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_kind             (in_kind),
    .in_desc_word_0      (in_desc_word_0),
    .in_desc_word_1      (in_desc_word_1),
    .in_desc_word_2      (in_desc_word_2),
    .in_desc_word_3      (in_desc_word_3),
    .in_octave           (in_octave),
    .in_cand_index       (in_cand_index),
    .in_taken            (in_taken),
    .out_valid           (out_valid),
    .out_accepted        (out_accepted),
    .out_best_index      (out_best_index),
    .out_best_distance   (out_best_distance),
    .out_second_distance (out_second_distance),
    .mismatch_count      (mismatch_count),
    .pending_results     (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic logic [DESC_W-1:0] random_desc();
    logic [DESC_W-1:0] d;
    for (int i = 0; i < DESC_W / 32; i++)
      d[32*i +: 32] = $urandom;
    return d;
  endfunction

  function automatic logic [DESC_W-1:0] weight_mask(input int k);
    return ~({DESC_W{1'b1}} << k);
  endfunction

  function automatic logic [DESC_W-1:0] flip_bits(input logic [DESC_W-1:0] base, input int n);
    logic [DESC_W-1:0] d;
    d = base;
    for (int i = 0; i < n; i++)
      d[$urandom_range(0, DESC_W - 1)] ^= 1'b1;
    return d;
  endfunction

  task automatic send_item(input logic [1:0] kind, input logic [DESC_W-1:0] desc,
                           input logic [bdrm_pkg::OCT_BITS-1:0] oct,
                           input logic [bdrm_pkg::IDX_BITS-1:0] idx,
                           input logic tk);
    int gap;
    if (gaps_on && items_sent < QUIET_AFTER && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      @(negedge clk);
      start = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start          = 1'b1;
    in_kind        = kind;
    in_desc_word_0 = desc[0 +: bdrm_pkg::WORD_BITS];
    in_desc_word_1 = desc[bdrm_pkg::WORD_BITS +: bdrm_pkg::WORD_BITS];
    in_desc_word_2 = desc[2*bdrm_pkg::WORD_BITS +: bdrm_pkg::WORD_BITS];
    in_desc_word_3 = desc[3*bdrm_pkg::WORD_BITS +: bdrm_pkg::WORD_BITS];
    in_octave      = oct;
    in_cand_index  = idx;
    in_taken       = tk;
    do @(posedge clk); while (busy);
    items_sent++;
  endtask

  task automatic drain_results();
    @(negedge clk);
    start = 1'b0;
    while (pending_results != 0) @(negedge clk);
  endtask

  task automatic run_search();
    logic [DESC_W-1:0] query;
    logic [DESC_W-1:0] cand;
    int                count;
    int                spread;
    int                level_top;
    int                mode;
    query = random_desc();
    send_item(bdrm_pkg::KIND_QUERY, query, 3'($urandom_range(0, 7)),
              10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    count     = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30) : $urandom_range(0, 8);
    spread    = ($urandom_range(0, 3) == 0) ? 128 : $urandom_range(4, 40);
    level_top = $urandom_range(0, 1) ? 1 : 7;
    repeat (count) begin
      mode = $urandom_range(0, 15);
      case (mode)
        0:       cand = ~query;
        1:       cand = random_desc();
        2:       cand = query;
        default: cand = flip_bits(query, $urandom_range(0, spread));
      endcase
      send_item(bdrm_pkg::KIND_CAND, cand, 3'($urandom_range(0, level_top)),
                10'($urandom_range(0, 1023)), $urandom_range(0, 5) == 0);
    end
    send_item(bdrm_pkg::KIND_FINISH, random_desc(), 3'($urandom_range(0, 7)),
              10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 7) == 0)
      send_item(bdrm_pkg::KIND_FINISH, random_desc(), 3'($urandom_range(0, 7)),
                10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
  endtask

  initial begin
    rst_n          = 1'b0;
    start          = 1'b0;
    in_kind        = bdrm_pkg::KIND_QUERY;
    in_desc_word_0 = '0;
    in_desc_word_1 = '0;
    in_desc_word_2 = '0;
    in_desc_word_3 = '0;
    in_octave      = '0;
    in_cand_index  = '0;
    in_taken       = 1'b0;
    items_sent     = 0;
    gaps_on        = 1'b0;
    paused_once    = 1'b0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    send_item(bdrm_pkg::KIND_CAND, weight_mask(3), 3'd2, 10'd5, 1'b0);
    send_item(bdrm_pkg::KIND_FINISH, '0, '0, '0, 1'b0);
    send_item(bdrm_pkg::KIND_FINISH, {DESC_W{1'b1}}, 3'd7, 10'd1023, 1'b1);
    send_item(bdrm_pkg::KIND_QUERY, {DESC_W{1'b1}}, 3'd7, 10'd1023, 1'b1);
    send_item(bdrm_pkg::KIND_FINISH, '0, '0, '0, 1'b0);
    send_item(bdrm_pkg::KIND_CAND, '0, 3'd3, 10'd7, 1'b0);
    send_item(bdrm_pkg::KIND_CAND, {DESC_W{1'b1}}, 3'd3, 10'd8, 1'b1);
    send_item(KIND_UNUSED, random_desc(), 3'd5, 10'd9, 1'b1);
    send_item(bdrm_pkg::KIND_FINISH, '0, '0, '0, 1'b0);
    send_item(bdrm_pkg::KIND_QUERY, '0, '0, '0, 1'b0);
    send_item(bdrm_pkg::KIND_CAND, weight_mask(4), 3'd1, 10'd1023, 1'b0);
    send_item(bdrm_pkg::KIND_CAND, weight_mask(5), 3'd1, 10'd0, 1'b0);
    send_item(bdrm_pkg::KIND_FINISH, '0, '0, '0, 1'b0);
    send_item(bdrm_pkg::KIND_QUERY, '0, '0, '0, 1'b0);
    send_item(bdrm_pkg::KIND_CAND, weight_mask(6), 3'd7, 10'd100, 1'b0);
    send_item(bdrm_pkg::KIND_CAND, weight_mask(5), 3'd7, 10'd200, 1'b0);
    send_item(bdrm_pkg::KIND_FINISH, '0, '0, '0, 1'b0);
    send_item(bdrm_pkg::KIND_CAND, ~weight_mask(251), 3'd0, 10'd300, 1'b0);
    send_item(bdrm_pkg::KIND_FINISH, '0, '0, '0, 1'b0);
    send_item(bdrm_pkg::KIND_CAND, '0, 3'd7, 10'd1023, 1'b0);
    send_item(bdrm_pkg::KIND_FINISH, '0, '0, '0, 1'b0);
    drain_results();

    while (items_sent < ITEM_TOTAL) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      if (!paused_once && items_sent >= ITEM_TOTAL / 2) begin
        drain_results();
        paused_once = 1'b1;
      end
      if ($urandom_range(0, 7) == 0)
        send_item(2'($urandom_range(0, 3)), random_desc(), 3'($urandom_range(0, 7)),
                  10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
      else
        run_search();
    end

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

>>> files.f
sv/bdrm_pkg.sv
sv/bdrm_ctrl.sv
sv/bdrm_datapath.sv
sv/binary_descriptor_ratio_matcher_core.sv
tb/bdrm_match_checker.sv
tb/binary_descriptor_ratio_matcher_core_tb.sv
